>>> hw/rtl/dbre_pkg.sv
package dbre_pkg;

    // Fixed field widths
    localparam int COEFF_W = 16;
    localparam int MAG_W   = 16;
    localparam int POS_W   = 6;
    localparam int QUANT_W = 6;
    localparam int RUN_W   = 6;
    localparam int VAL_W   = 10;
    localparam int WORD_W  = 16;

    // Defaults for top-level parameters
    localparam int BLOCK_SIZE_DEF = 64;
    localparam int FRAC_BITS_DEF  = 4;

    // Saturation limits of the signed 10-bit value (magnitudes)
    localparam logic [VAL_W-1:0] SAT_POS_MAG = 10'd511;
    localparam logic [VAL_W-1:0] SAT_NEG_MAG = 10'd512;

    // Register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_RLE_ENABLE   = 1'b0;
    localparam logic REG_QUANT_FACTOR = 1'b1;

    localparam logic             RLE_ENABLE_RST   = 1'b1;
    localparam logic [QUANT_W-1:0] QUANT_FACTOR_RST = 6'd1;

    // One classified coefficient, front to back
    typedef struct packed {
        logic               is_dc;
        logic               is_last;
        logic               rle;
        logic [QUANT_W-1:0] quant;
        logic               neg;
        logic [MAG_W-1:0]   mag;
    } item_t;

endpackage

>>> hw/rtl/dbre_front.sv
module dbre_front #(
    parameter int BLOCK_SIZE = dbre_pkg::BLOCK_SIZE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [dbre_pkg::COEFF_W-1:0] coeff,
    input  logic                                rle_enable,
    input  logic [dbre_pkg::QUANT_W-1:0]        quant_factor,
    output logic                                q_valid,
    input  logic                                q_ready,
    output dbre_pkg::item_t                     q_item
);

    localparam logic [dbre_pkg::POS_W-1:0] LAST_POS = dbre_pkg::POS_W'(BLOCK_SIZE - 1);

    logic [dbre_pkg::POS_W-1:0] position_reg;
    logic [dbre_pkg::POS_W-1:0] position_next;
    logic [dbre_pkg::COEFF_W-1:0] raw;
    logic                         is_last;
    logic                         accept;

    assign raw      = coeff;
    assign is_last  = (position_reg >= LAST_POS);
    assign accept   = in_valid && q_ready;
    assign in_ready = q_ready;
    assign q_valid  = in_valid;

    always_comb
    begin
        q_item.is_dc   = (position_reg == '0);
        q_item.is_last = is_last;
        q_item.rle     = rle_enable;
        q_item.quant   = quant_factor;
        q_item.neg     = raw[dbre_pkg::COEFF_W-1];
        q_item.mag     = raw[dbre_pkg::COEFF_W-1] ? (dbre_pkg::MAG_W'(0) - raw) : raw;
    end

    always_comb
    begin
        position_next = position_reg;
        if (accept)
        begin
            position_next = is_last ? '0 : position_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
        end
        else
        begin
            position_reg <= position_next;
        end
    end

endmodule

>>> hw/rtl/dbre_queue.sv
module dbre_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  dbre_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output dbre_pkg::item_t rd_item
);

    // Two entries
    dbre_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/dbre_back.sv
module dbre_back #(
    parameter int FRAC_BITS = dbre_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_ready,
    input  dbre_pkg::item_t                   q_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dbre_pkg::WORD_W-1:0]       code_word,
    output logic                              block_end
);

    // divisor = q << FRAC_BITS; numerator 2*mag + divisor, denominator 2*divisor
    localparam int DIV_W  = dbre_pkg::QUANT_W + FRAC_BITS;
    localparam int DEN_W  = DIV_W + 1;
    localparam int MAG2_W = dbre_pkg::MAG_W + 1;
    localparam int NUM_W  = ((MAG2_W > DIV_W) ? MAG2_W : DIV_W) + 1;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int VAL_W  = dbre_pkg::VAL_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                         state_reg,   state_next;
    dbre_pkg::item_t                item_reg,    item_next;
    logic [DEN_W-1:0]               den_reg,     den_next;
    logic [DEN_W-1:0]               rem_reg,     rem_next;
    logic [NUM_W-1:0]               numq_reg,    numq_next;
    logic [CNT_W-1:0]               cnt_reg,     cnt_next;
    logic [dbre_pkg::RUN_W-1:0]     run_reg,     run_next;
    logic                           ovalid_reg,  ovalid_next;
    logic [dbre_pkg::WORD_W-1:0]    word_reg,    word_next;
    logic                           end_reg,     end_next;

    logic [dbre_pkg::QUANT_W-1:0]   q_eff;
    logic [DIV_W-1:0]               div_val;
    logic [DEN_W:0]                 rem_sh;
    logic                           ge;
    logic [VAL_W-1:0]               sat_mag;
    logic [VAL_W-1:0]               ac;
    logic                           emit;
    logic                           slot_free;
    logic                           proceed;
    logic [dbre_pkg::WORD_W-1:0]    emit_word;
    logic                           emit_end;

    assign out_valid = ovalid_reg;
    assign code_word = word_reg;
    assign block_end = end_reg;
    assign q_ready   = (state_reg == S_IDLE);

    // divisor set-up from the queued item
    always_comb
    begin
        q_eff   = (q_item.quant == '0) ? dbre_pkg::QUANT_W'(1) : q_item.quant;
        div_val = DIV_W'(q_item.is_dc ? dbre_pkg::QUANT_W'(1) : q_eff) << FRAC_BITS;
    end

    // one restoring step
    assign rem_sh = {rem_reg, numq_reg[NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    // rounding done by the divide; saturate to signed 10 bits
    always_comb
    begin
        if (item_reg.neg)
        begin
            sat_mag = (numq_reg > NUM_W'(dbre_pkg::SAT_NEG_MAG)) ?
                      dbre_pkg::SAT_NEG_MAG : numq_reg[VAL_W-1:0];
            ac      = VAL_W'(0) - sat_mag;
        end
        else
        begin
            sat_mag = (numq_reg > NUM_W'(dbre_pkg::SAT_POS_MAG)) ?
                      dbre_pkg::SAT_POS_MAG : numq_reg[VAL_W-1:0];
            ac      = sat_mag;
        end
    end

    // word selection
    always_comb
    begin
        emit      = 1'b1;
        emit_end  = item_reg.is_last;
        emit_word = {run_reg, ac};
        if (item_reg.is_dc)
        begin
            emit_word = {item_reg.quant, ac};
            emit_end  = 1'b0;
        end
        else if (!item_reg.rle)
        begin
            emit_word = {dbre_pkg::RUN_W'(0), ac};
        end
        else if (ac != '0)
        begin
            emit_word = {run_reg, ac};
        end
        else if (item_reg.is_last)
        begin
            emit_word = {run_reg, VAL_W'(0)};
        end
        else
        begin
            emit = 1'b0;
        end
    end

    assign slot_free = !ovalid_reg || out_ready;
    assign proceed   = !emit || slot_free;

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        numq_next   = numq_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        ovalid_next = ovalid_reg && !out_ready;
        word_next   = word_reg;
        end_next    = end_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_next  = q_item;
                    den_next   = {div_val, 1'b0};
                    numq_next  = NUM_W'({q_item.mag, 1'b0}) + NUM_W'(div_val);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
                numq_next = {numq_reg[NUM_W-2:0], ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (proceed)
                begin
                    if (emit)
                    begin
                        ovalid_next = 1'b1;
                        word_next   = emit_word;
                        end_next    = emit_end;
                        run_next    = '0;
                    end
                    else
                    begin
                        run_next = run_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        numq_reg <= numq_next;
        cnt_reg  <= cnt_next;
        word_reg <= word_next;
        end_reg  <= end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            run_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            run_reg    <= run_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

>>> hw/rtl/dct_block_rle_encoder.sv
// Zero run-length encoder for blocks of transform coefficients.
// Input channel (in_valid/in_ready, coeff): BLOCK_SIZE signed coefficients
// per block, DC first. Output channel (out_valid/out_ready, code_word,
// block_end): one header word per block (quantizer in bits 15:10, rounded
// DC in 9:0), then AC words of run<<10 | value; block_end marks the last.
// Registers over the APB port: 0x0 rle_enable, 0x4 quant_factor.
// Throughput is set by the one-bit-per-cycle restoring divider in the
// back end, which takes no new item until it is through with the last.
// The front end stamps each item with its block position and the current
// register values and parks it in a two-entry queue, so up to two items
// are taken while the divider is busy.
// Reset: block position and pending zero count return to zero, registers
// to rle_enable=1, quant_factor=1, output empty. No clearing pass.
// When the receiver stalls the output word holds; the divider finishes
// its item and waits, and in_ready drops once the queue is full.
module dct_block_rle_encoder #(
    parameter int BLOCK_SIZE = dbre_pkg::BLOCK_SIZE_DEF,
    parameter int FRAC_BITS  = dbre_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [dbre_pkg::COEFF_W-1:0] coeff,
    // item output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dbre_pkg::WORD_W-1:0]         code_word,
    output logic                                block_end,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dbre_pkg::ADDR_W-1:0]         paddr,
    input  logic [dbre_pkg::DATA_W-1:0]         pwdata,
    output logic [dbre_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    logic                          rle_reg,   rle_next;
    logic [dbre_pkg::QUANT_W-1:0]  quant_reg, quant_next;
    logic                          wr_en;
    logic                          reg_sel;

    logic            fq_valid;
    logic            fq_ready;
    dbre_pkg::item_t fq_item;
    logic            qb_valid;
    logic            qb_ready;
    dbre_pkg::item_t qb_item;

    // register file; index from address bit 2 (registers at 0x0 and 0x4)
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_comb
    begin
        rle_next   = rle_reg;
        quant_next = quant_reg;
        if (wr_en)
        begin
            case (reg_sel)
                dbre_pkg::REG_RLE_ENABLE:   rle_next   = pwdata[0];
                dbre_pkg::REG_QUANT_FACTOR: quant_next = pwdata[dbre_pkg::QUANT_W-1:0];
                default:                    rle_next   = rle_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            dbre_pkg::REG_RLE_ENABLE:   prdata = dbre_pkg::DATA_W'(rle_reg);
            dbre_pkg::REG_QUANT_FACTOR: prdata = dbre_pkg::DATA_W'(quant_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_reg   <= dbre_pkg::RLE_ENABLE_RST;
            quant_reg <= dbre_pkg::QUANT_FACTOR_RST;
        end
        else
        begin
            rle_reg   <= rle_next;
            quant_reg <= quant_next;
        end
    end

    // front: block position and classification
    dbre_front #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .coeff        (coeff),
        .rle_enable   (rle_reg),
        .quant_factor (quant_reg),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_item       (fq_item)
    );

    // two-entry decoupling queue
    dbre_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    // back: serial divide, saturate, run-length code, output register
    dbre_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_item    (qb_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .code_word (code_word),
        .block_end (block_end)
    );

endmodule

>>> hw/rtl/dbre_chk.sv
module dbre_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic signed [dbre_pkg::COEFF_W-1:0] coeff,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [dbre_pkg::WORD_W-1:0]         code_word,
    input logic                                block_end,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [dbre_pkg::ADDR_W-1:0]         paddr,
    input logic [dbre_pkg::DATA_W-1:0]         pwdata,
    input logic [dbre_pkg::DATA_W-1:0]         prdata,
    input logic                                pready
);

    // a waiting input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(coeff))
        else $error("input item changed while waiting");

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_word) && $stable(block_end))
        else $error("output item changed while stalled");

    // no output valid coming straight out of reset
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("output valid straight after reset");

    // quantizer written is read back
    a_quant_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[2] |=>
        (paddr[2] ? (prdata[5:0] == $past(pwdata[5:0])) : 1'b1) || $past(!rst_n))
        else $error("quant_factor readback mismatch");

    // rle enable written is read back
    a_rle_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && !paddr[2] |=>
        (!paddr[2] ? (prdata[0] == $past(pwdata[0])) : 1'b1))
        else $error("rle_enable readback mismatch");

endmodule

bind dct_block_rle_encoder dbre_chk u_chk (.*);
